@@ hdl/visibility_graph_edges_core_defines.svh @@
// Assertion macros for the visibility graph edge builder.
// Used by the top level; expects signals clk and rst in scope.
`ifndef VISIBILITY_GRAPH_EDGES_CORE_DEFINES_SVH
`define VISIBILITY_GRAPH_EDGES_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define VGE_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vge assertion failed");

// next-cycle implication
`define VGE_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vge assertion failed");

`else

`define VGE_ASSERT_IMP(label, ante, cons)
`define VGE_ASSERT_NXT(label, ante, cons)

`endif

`endif

@@ hdl/vge_pkg.sv @@
// Shared types and constants for the visibility graph edge builder.
// Used by vge_ctrl, vge_datapath and visibility_graph_edges_core.
`timescale 1ns / 1ps

package vge_pkg;

  localparam int MAX_SAMPLES = 64;
  localparam int SAMPLE_BITS = 16;
  localparam int IDX_W       = $clog2(MAX_SAMPLES);
  localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
  localparam int RISE_W      = SAMPLE_BITS + 1;
  localparam int RUN_W       = IDX_W;
  localparam int PROD_W      = RISE_W + RUN_W + 1;
  localparam int INDEX_W     = 6;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          series_start;
  } sample_item_t;

  typedef struct packed {
    logic [INDEX_W-1:0] from_index;
    logic [INDEX_W-1:0] to_index;
    logic               last_in_run;
    logic               overflow;
  } edge_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_OVF
  } state_t;

  typedef struct packed {
    logic load;
    logic advance;
    logic issue;
    logic ovf_push;
  } dp_cmd_t;

  typedef struct packed {
    logic ovf_case;
    logic first;
    logic reads_left;
    logic eval_push;
    logic out_free;
  } dp_status_t;

endpackage

@@ hdl/visibility_graph_edges_core.sv @@
// Natural visibility graph edge builder: takes one sample at a time and emits every
// new edge as an index pair. For a sample stored at index n, the scan walks the n
// earlier points one per cycle behind a registered read, as the slope store has one
// read port, and pauses while edge_stall holds a pending edge; sample_stall holds
// new samples off until it ends. The first sample of a series gives no edge; a sample
// that meets a full store gives one overflow item. Edges leave through an output
// register. Depends on vge_pkg, vge_ctrl, vge_datapath and the defines header.
`timescale 1ns / 1ps
`include "visibility_graph_edges_core_defines.svh"

module visibility_graph_edges_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  sample_valid,
  output logic                  sample_stall,
  input  vge_pkg::sample_item_t sample_item,
  output logic                  edge_valid,
  input  logic                  edge_stall,
  output vge_pkg::edge_item_t   edge_item
);

  vge_pkg::dp_cmd_t    cmd;
  vge_pkg::dp_status_t st;

  vge_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .st           (st),
    .cmd          (cmd)
  );

  vge_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .sample_item (sample_item),
    .cmd         (cmd),
    .st          (st),
    .edge_stall  (edge_stall),
    .edge_valid  (edge_valid),
    .edge_item   (edge_item)
  );

  `VGE_ASSERT_IMP(a_no_push_over_held, edge_valid && edge_stall, !cmd.ovf_push && !(cmd.advance && st.eval_push))
  `VGE_ASSERT_IMP(a_ovf_item_zero, edge_valid && edge_item.overflow, edge_item.from_index == '0 && edge_item.to_index == '0 && !edge_item.last_in_run)
  `VGE_ASSERT_IMP(a_edge_ordered, edge_valid && !edge_item.overflow, edge_item.from_index < edge_item.to_index)
  `VGE_ASSERT_NXT(a_scan_busy, cmd.issue, sample_stall)

endmodule

@@ hdl/vge_ctrl.sv @@
// Controller state machine for the visibility graph edge builder.
// Depends on vge_pkg; drives commands into vge_datapath.
`timescale 1ns / 1ps

module vge_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                sample_valid,
  output logic                sample_stall,
  input  vge_pkg::dp_status_t st,
  output vge_pkg::dp_cmd_t    cmd
);

  vge_pkg::state_t state;
  vge_pkg::state_t state_next;
  logic            adv;

  assign adv = st.eval_push ? st.out_free : 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= vge_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      vge_pkg::ST_IDLE: begin
        if (sample_valid) begin
          if (st.ovf_case) begin
            state_next = vge_pkg::ST_OVF;
          end else if (!st.first) begin
            state_next = vge_pkg::ST_SCAN;
          end
        end
      end
      vge_pkg::ST_SCAN: begin
        if (adv && !st.reads_left) begin
          state_next = vge_pkg::ST_IDLE;
        end
      end
      vge_pkg::ST_OVF: begin
        if (st.out_free) begin
          state_next = vge_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = vge_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    sample_stall = 1'b1;
    cmd          = '0;
    unique case (state)
      vge_pkg::ST_IDLE: begin
        sample_stall = 1'b0;
        cmd.load     = sample_valid;
      end
      vge_pkg::ST_SCAN: begin
        cmd.advance = adv;
        cmd.issue   = adv && st.reads_left;
      end
      vge_pkg::ST_OVF: begin
        cmd.ovf_push = st.out_free;
      end
      default: begin
        sample_stall = 1'b1;
      end
    endcase
  end

endmodule

@@ hdl/vge_datapath.sv @@
// Datapath: sample and slope stores, scan pipeline, slope compare, edge register.
// Depends on vge_pkg; commanded by vge_ctrl.
`timescale 1ns / 1ps

module vge_datapath (
  input  logic                  clk,
  input  logic                  rst,
  input  vge_pkg::sample_item_t sample_item,
  input  vge_pkg::dp_cmd_t      cmd,
  output vge_pkg::dp_status_t   st,
  input  logic                  edge_stall,
  output logic                  edge_valid,
  output vge_pkg::edge_item_t   edge_item
);

  logic signed [vge_pkg::SAMPLE_BITS-1:0] smp_mem  [vge_pkg::MAX_SAMPLES];
  logic signed [vge_pkg::RISE_W-1:0]      rise_mem [vge_pkg::MAX_SAMPLES];
  logic [vge_pkg::RUN_W-1:0]              run_mem  [vge_pkg::MAX_SAMPLES];

  logic [vge_pkg::CNT_W-1:0]              sample_count;
  logic [vge_pkg::CNT_W-1:0]              cnt_eff;
  logic [vge_pkg::IDX_W-1:0]              n_idx;
  logic [vge_pkg::IDX_W-1:0]              n_m1;
  logic [vge_pkg::IDX_W-1:0]              scan_idx;
  logic [vge_pkg::IDX_W-1:0]              eval_idx;
  logic [vge_pkg::RUN_W-1:0]              run;
  logic                                   eval_valid;
  logic                                   hit;
  logic                                   load_ok;
  logic                                   slope_we;
  logic signed [vge_pkg::SAMPLE_BITS-1:0] x_q;
  logic signed [vge_pkg::SAMPLE_BITS-1:0] s_q;
  logic signed [vge_pkg::RISE_W-1:0]      rise_q;
  logic signed [vge_pkg::RISE_W-1:0]      rise;
  logic [vge_pkg::RUN_W-1:0]              run_q;
  logic signed [vge_pkg::PROD_W-1:0]      p_new;
  logic signed [vge_pkg::PROD_W-1:0]      p_old;

  assign cnt_eff = sample_item.series_start ? '0 : sample_count;
  assign load_ok = cmd.load && !st.ovf_case;

  assign n_m1  = n_idx - vge_pkg::IDX_W'(1);
  assign run   = n_idx - eval_idx;
  assign rise  = vge_pkg::RISE_W'(x_q) - vge_pkg::RISE_W'(s_q);
  assign p_new = vge_pkg::PROD_W'(rise) * vge_pkg::PROD_W'($signed({1'b0, run_q}));
  assign p_old = vge_pkg::PROD_W'(rise_q) * vge_pkg::PROD_W'($signed({1'b0, run}));
  assign hit   = (eval_idx == n_m1) || (p_new > p_old);

  assign st.ovf_case   = cnt_eff == vge_pkg::CNT_W'(vge_pkg::MAX_SAMPLES);
  assign st.first      = cnt_eff == '0;
  assign st.reads_left = scan_idx != n_idx;
  assign st.eval_push  = eval_valid && hit;
  assign st.out_free   = !edge_valid || !edge_stall;

  assign slope_we = cmd.advance && st.eval_push;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_count <= '0;
      scan_idx     <= '0;
      eval_valid   <= 1'b0;
      edge_valid   <= 1'b0;
    end else begin
      if (load_ok) begin
        sample_count <= cnt_eff + vge_pkg::CNT_W'(1);
      end
      if (cmd.load) begin
        scan_idx   <= '0;
        eval_valid <= 1'b0;
      end else if (cmd.advance) begin
        eval_valid <= cmd.issue;
        if (cmd.issue) begin
          scan_idx <= scan_idx + vge_pkg::IDX_W'(1);
        end
      end
      if (cmd.ovf_push || slope_we) begin
        edge_valid <= 1'b1;
      end else if (!edge_stall) begin
        edge_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_ok) begin
      x_q   <= sample_item.sample;
      n_idx <= cnt_eff[vge_pkg::IDX_W-1:0];
    end
    if (cmd.advance) begin
      eval_idx <= scan_idx;
    end
    if (cmd.ovf_push) begin
      edge_item <= '{from_index: '0, to_index: '0, last_in_run: 1'b0, overflow: 1'b1};
    end else if (slope_we) begin
      edge_item.from_index  <= vge_pkg::INDEX_W'(eval_idx);
      edge_item.to_index    <= vge_pkg::INDEX_W'(n_idx);
      edge_item.last_in_run <= eval_idx == n_m1;
      edge_item.overflow    <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_ok) begin
      smp_mem[cnt_eff[vge_pkg::IDX_W-1:0]] <= sample_item.sample;
    end
    if (cmd.issue) begin
      s_q <= smp_mem[scan_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (slope_we) begin
      rise_mem[eval_idx] <= rise;
      run_mem[eval_idx]  <= run;
    end
    if (cmd.issue) begin
      rise_q <= rise_mem[scan_idx];
      run_q  <= run_mem[scan_idx];
    end
  end

endmodule
